// ===== rtl/rtc_three_wire_bus_master_macros.svh =====
// Assertion macros used by the three-wire bus master core.
`ifndef RTC_THREE_WIRE_BUS_MASTER_MACROS_SVH
`define RTC_THREE_WIRE_BUS_MASTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTC3W_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtc3w assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RTC3W_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtc3w assertion failed");

`endif

// ===== rtl/rtc3w_pkg.sv =====
// Package with the types, constants and helper functions of the three-wire bus master.
`default_nettype none

package rtc3w_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ENLOW   = 3'd1,
        PH_BITLOW  = 3'd2,
        PH_BITHIGH = 3'd3,
        PH_FINISH  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_READ     = 2'd1,
        OP_READ_DEC = 2'd2,
        OP_SAVE     = 2'd3
    } op_t;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
    localparam logic [7:0]  WP_ADDRESS        = 8'h8E;
    localparam logic [7:0]  WP_UNLOCK         = 8'h00;
    localparam logic [7:0]  WP_LOCK           = 8'h80;
    localparam logic [7:0]  WRITE_MASK        = 8'hFE;
    localparam logic [7:0]  READ_FLAG         = 8'h01;
    localparam logic [7:0]  BCD_MAX           = 8'd99;
    localparam logic [3:0]  LAST_BIT          = 4'd15;
    localparam logic [1:0]  SAVE_LAST_STEP    = 2'd2;
    localparam logic [1:0]  SAVE_UNLOCK_STEP  = 2'd0;
    localparam logic [1:0]  SAVE_DATA_STEP    = 2'd1;

    typedef struct packed {
        logic       start_req;
        logic [1:0] opcode;
        logic [7:0] reg_address;
        logic [7:0] value;
        logic       data_pin;
    } item_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       data_out;
        logic       data_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_index;
        logic [15:0] tick_count;
        logic [7:0]  address_shift;
        logic [7:0]  data_shift;
        logic [7:0]  captured_byte;
        op_t         held_opcode;
        logic [1:0]  sub_step;
        logic [7:0]  held_value;
        logic [7:0]  held_address;
    } state_t;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
    } shift_pair_t;

    // Clamps a binary value to 99 and returns it as two BCD digits.
    function automatic logic [7:0] to_bcd_clamped(input logic [7:0] v);
        logic [6:0]  d;
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  ones;
        d        = (v > BCD_MAX) ? BCD_MAX[6:0] : v[6:0];
        prod     = 14'(d) * 14'd103;
        tens     = prod[13:10];
        tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        ones     = d - tens_x10;
        return {tens, ones[3:0]};
    endfunction

    // Converts a byte of two BCD digits to binary.
    function automatic logic [7:0] from_bcd(input logic [7:0] b);
        return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
    endfunction

    function automatic logic is_read_op(input op_t op);
        return (op == OP_READ) || (op == OP_READ_DEC);
    endfunction

    // Address and data bytes that one transaction of a command shifts out.
    function automatic shift_pair_t load_shifts(input op_t op, input logic [1:0] step,
                                                input logic [7:0] addr,
                                                input logic [7:0] val);
        shift_pair_t sp;
        if (op == OP_SAVE) begin
            if (step == SAVE_UNLOCK_STEP) begin
                sp.addr = WP_ADDRESS;
                sp.data = WP_UNLOCK;
            end
            else if (step == SAVE_DATA_STEP) begin
                sp.addr = addr & WRITE_MASK;
                sp.data = to_bcd_clamped(val);
            end
            else begin
                sp.addr = WP_ADDRESS;
                sp.data = WP_LOCK;
            end
        end
        else if (is_read_op(op)) begin
            sp.addr = addr | READ_FLAG;
            sp.data = '0;
        end
        else begin
            sp.addr = addr & WRITE_MASK;
            sp.data = val;
        end
        return sp;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rtc3w_ifs.sv =====
// Handshake channel interfaces for tick items, result items and the configuration write.
`default_nettype none

interface rtc3w_item_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [1:0] opcode;
    logic [7:0] reg_address;
    logic [7:0] value;
    logic       data_pin;

    modport source (output valid, start_req, opcode, reg_address, value, data_pin,
                    input ready);
    modport sink (input valid, start_req, opcode, reg_address, value, data_pin,
                  output ready);
endinterface

interface rtc3w_result_if;
    logic       valid;
    logic       ready;
    logic       chip_enable;
    logic       serial_clock;
    logic       data_out;
    logic       data_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;

    modport source (output valid, chip_enable, serial_clock, data_out, data_drive,
                    busy_res, done_res, read_value, input ready);
    modport sink (input valid, chip_enable, serial_clock, data_out, data_drive,
                  busy_res, done_res, read_value, output ready);
endinterface

interface rtc3w_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] half_period_ticks;

    modport source (output valid, half_period_ticks, input ready);
    modport sink (input valid, half_period_ticks, output ready);
endinterface

`default_nettype wire

// ===== rtl/rtc3w_core.sv =====
// Bus sequencer: state registers and the per-tick next-state and line-level logic.
`default_nettype none

module rtc3w_core
    import rtc3w_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire item_t       item,
    input  wire logic [15:0] half_period,
    output result_t          res
);

    `include "rtc_three_wire_bus_master_macros.svh"

    state_t      state_reg;
    state_t      state_next;
    state_t      eff;
    shift_pair_t start_load;
    shift_pair_t step_load;
    logic [15:0] hp;
    logic        tick_wrap;
    logic        is_read;
    logic        rx;
    logic        more_tx;

    assign start_load = load_shifts(op_t'(item.opcode), SAVE_UNLOCK_STEP,
                                    item.reg_address, item.value);

    // A start in idle loads the command before the tick is processed.
    always_comb
    begin
        eff = state_reg;
        if (state_reg.phase == PH_IDLE && item.start_req)
        begin
            eff.held_opcode   = op_t'(item.opcode);
            eff.held_address  = item.reg_address;
            eff.held_value    = item.value;
            eff.sub_step      = SAVE_UNLOCK_STEP;
            eff.captured_byte = '0;
            eff.address_shift = start_load.addr;
            eff.data_shift    = start_load.data;
            eff.bit_index     = '0;
            eff.tick_count    = '0;
            eff.phase         = PH_ENLOW;
        end
    end

    assign hp        = (half_period == '0) ? 16'd1 : half_period;
    assign tick_wrap = ({1'b0, eff.tick_count} + 17'd1) >= {1'b0, hp};
    assign is_read   = is_read_op(eff.held_opcode);
    assign rx        = eff.bit_index[3] && is_read;
    assign more_tx   = (eff.held_opcode == OP_SAVE) && (eff.sub_step < SAVE_LAST_STEP);
    assign step_load = load_shifts(eff.held_opcode, eff.sub_step + 2'd1,
                                   eff.held_address, eff.held_value);

    always_comb
    begin
        state_next = eff;
        case (eff.phase)
            PH_IDLE:
            begin
                state_next = eff;
            end
            PH_ENLOW:
            begin
                if (tick_wrap)
                begin
                    state_next.tick_count = '0;
                    state_next.bit_index  = '0;
                    state_next.phase      = PH_BITLOW;
                end
                else
                begin
                    state_next.tick_count = eff.tick_count + 16'd1;
                end
            end
            PH_BITLOW:
            begin
                if (rx)
                begin
                    state_next.captured_byte = {item.data_pin, eff.captured_byte[7:1]};
                end
                state_next.tick_count = '0;
                state_next.phase      = PH_BITHIGH;
            end
            PH_BITHIGH:
            begin
                if (tick_wrap)
                begin
                    state_next.tick_count = '0;
                    if (!eff.bit_index[3])
                    begin
                        state_next.address_shift = {1'b0, eff.address_shift[7:1]};
                    end
                    else
                    begin
                        state_next.data_shift = {1'b0, eff.data_shift[7:1]};
                    end
                    if (eff.bit_index == LAST_BIT)
                    begin
                        state_next.phase = PH_FINISH;
                    end
                    else
                    begin
                        state_next.bit_index = eff.bit_index + 4'd1;
                        state_next.phase     = PH_BITLOW;
                    end
                end
                else
                begin
                    state_next.tick_count = eff.tick_count + 16'd1;
                end
            end
            PH_FINISH:
            begin
                if (more_tx)
                begin
                    state_next.sub_step      = eff.sub_step + 2'd1;
                    state_next.address_shift = step_load.addr;
                    state_next.data_shift    = step_load.data;
                    state_next.bit_index     = '0;
                    state_next.tick_count    = '0;
                    state_next.phase         = PH_ENLOW;
                end
                else
                begin
                    state_next.phase      = PH_IDLE;
                    state_next.bit_index  = '0;
                    state_next.tick_count = '0;
                end
            end
            default:
            begin
                state_next.phase = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res = '0;
        case (eff.phase)
            PH_IDLE:
            begin
                res = '0;
            end
            PH_ENLOW:
            begin
                res.busy_res   = 1'b1;
                res.data_drive = 1'b1;
            end
            PH_BITLOW, PH_BITHIGH:
            begin
                res.busy_res     = 1'b1;
                res.chip_enable  = 1'b1;
                res.serial_clock = (eff.phase == PH_BITHIGH);
                if (!rx)
                begin
                    res.data_drive = 1'b1;
                    res.data_out   = eff.bit_index[3] ? eff.data_shift[0]
                                                      : eff.address_shift[0];
                end
            end
            PH_FINISH:
            begin
                if (more_tx)
                begin
                    res.busy_res = 1'b1;
                end
                else
                begin
                    res.done_res = 1'b1;
                    if (eff.held_opcode == OP_READ)
                    begin
                        res.read_value = eff.captured_byte;
                    end
                    else if (eff.held_opcode == OP_READ_DEC)
                    begin
                        res.read_value = from_bcd(eff.captured_byte);
                    end
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

    `RTC3W_ASSERT_SAME(a_done_not_busy, res.done_res, !res.busy_res)
    `RTC3W_ASSERT_SAME(a_read_value_with_done, res.read_value != '0, res.done_res)
    `RTC3W_ASSERT_SAME(a_released_line_low, !res.data_drive, !res.data_out)
    `RTC3W_ASSERT_NEXT(a_done_returns_idle, step_en && res.done_res,
                       state_reg.phase == PH_IDLE)
    `RTC3W_ASSERT_NEXT(a_idle_holds, step_en && state_reg.phase == PH_IDLE && !item.start_req,
                       state_reg.phase == PH_IDLE)

endmodule

`default_nettype wire

// ===== rtl/rtc_three_wire_bus_master.sv =====
// Top level of the three-wire serial bus master for a real-time clock chip.
`default_nettype none

// Each beat on the item channel is one timing tick and yields exactly one beat on the
// result channel with the bus line levels for that tick, plus busy, a done pulse and the
// byte read. The block takes one tick per clock cycle while the result channel is not
// stalled by result ready; a tick passes through the input register, the sequencer step
// and then the result register, where it waits until result ready takes it. The half
// period register must be written through the configuration channel only while no command
// is running; the block itself does not enforce this. Zero acts as one tick.
module rtc_three_wire_bus_master
    import rtc3w_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    rtc3w_item_if.sink       item,
    rtc3w_result_if.source   result,
    rtc3w_cfg_if.sink        cfg
);

    logic        half_period_reg;
    logic [15:0] half_period_ticks_reg;
    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_item_reg;
    result_t     step_res;
    logic        advance;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg       <= 1'b0;
            half_period_ticks_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            half_period_reg       <= 1'b1;
            half_period_ticks_reg <= cfg.half_period_ticks;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg.start_req   <= item.start_req;
            in_item_reg.opcode      <= item.opcode;
            in_item_reg.reg_address <= item.reg_address;
            in_item_reg.value       <= item.value;
            in_item_reg.data_pin    <= item.data_pin;
        end
    end

    rtc3w_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .item        (in_item_reg),
        .half_period (half_period_reg ? half_period_ticks_reg : HALF_PERIOD_RESET),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.chip_enable  = out_item_reg.chip_enable;
    assign result.serial_clock = out_item_reg.serial_clock;
    assign result.data_out     = out_item_reg.data_out;
    assign result.data_drive   = out_item_reg.data_drive;
    assign result.busy_res     = out_item_reg.busy_res;
    assign result.done_res     = out_item_reg.done_res;
    assign result.read_value   = out_item_reg.read_value;

endmodule

`default_nettype wire
